FILE: rtl/wsdc_pkg.sv
// wheel speed and distance calculator: shared constants, codes and types
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps

package wsdc_pkg;

    // state widths
    localparam int DISTANCE_BITS = 40;
    localparam int TIME_BITS     = 32;
    localparam int ROT_BITS      = 16;
    localparam int CIRC_BITS     = 10;
    localparam int ADD_BITS      = CIRC_BITS + ROT_BITS;

    // numerator of a speed division: centimetres times 3600
    localparam int AW  = (DISTANCE_BITS > ADD_BITS) ? DISTANCE_BITS : ADD_BITS;
    localparam int DVW = AW + 12;

    // quotient bits kept by the serial divider; anything at or above 2^QB saturates
    localparam int QB    = 21;
    localparam int QB_CW = $clog2(QB);
    localparam int CMPW  = (DVW > TIME_BITS) ? DVW : TIME_BITS;

    // divide-by-100 unit for the distance in metres: 16-bit digits, each quotient
    // digit by reciprocal multiplication (exact below 100 * 2^16)
    localparam int DIG_BITS  = 16;
    localparam int DIG_N     = (DISTANCE_BITS + DIG_BITS - 1) / DIG_BITS;
    localparam int DQ_W      = DIG_N * DIG_BITS;
    localparam int DQ_CW     = $clog2(2 * DIG_N);
    localparam int DR_W      = 7;
    localparam int DV_W      = DR_W + DIG_BITS;
    localparam int REC_BITS  = 24;
    localparam int REC_SHIFT = 30;
    localparam logic [REC_BITS-1:0] REC_100 = 24'd10737419;
    localparam int DM_W  = DISTANCE_BITS - 6;
    localparam logic [7:0] CM_PER_M = 8'd100;

    // result fields
    localparam int SPEED_BITS = 16;
    localparam int DIST_BITS  = 32;
    localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

    // mile factor 0.621371 in Q0.16
    localparam logic [15:0] MILE_Q16 = 16'd40722;

    // configuration
    localparam logic [CIRC_BITS-1:0] CIRC_RESET = 10'd190;
    localparam logic [1:0] CFG_CIRC = 2'd0;
    localparam logic [1:0] CFG_UNIT = 2'd1;

    typedef enum logic [1:0] {
        OP_ROT  = 2'd0,
        OP_TICK = 2'd1,
        OP_CALC = 2'd2,
        OP_TRIP = 2'd3
    } wsdc_op_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic rot_inc;
        logic tick;
        logic trip_clr;
        logic mul_add;
        logic sum;
        logic div_load;
        logic div_sel;      // 0 interval speed, 1 trip average speed
        logic div_init;
        logic div_step;
        logic div_end;
        logic speed_store;
        logic dist_start;
        logic dist_mul;
        logic out_load;
    } wsdc_cmd_t;

    // status back to the controller
    typedef struct packed {
        logic div_last;
        logic dist_busy;
    } wsdc_stat_t;

endpackage

FILE: rtl/wheel_speed_distance_calc.sv
// wheel speed and distance calculator: top level with the event stream,
// the result stream and the configuration port; depends on wsdc_pkg, wsdc_ctrl, wsdc_dp
`timescale 1ns / 1ps

// Usage
// Input stream s_*: one transaction per event; s_tuser carries the opcode
// (wheel rotation, millisecond tick, calculate, reset trip), s_tdata bit 0 the
// calculate enable. Rotation, tick, trip reset and a disabled calculate give no
// result; s_tready stays high for them.
// An enabled calculate gives one result transaction on m_*: current speed,
// average speed and trip distance. m_tvalid rises after two passes of the
// serial speed divider (21 quotient bits, one per cycle) plus setup and
// scaling steps; the divide by 100 for the distance runs beside the first
// pass. s_tready is low during that work, so a new event is not taken until
// the result is loaded.
// The result waits in an output register: events keep being accepted while
// m_tready is low, and a following calculate stalls only at its final load.
// Configuration: cfg_ready is always high; index 0 wheel circumference in cm,
// index 1 unit mode (0 metric, 1 imperial). Write only while idle.
// Reset (rst_n low, asynchronous) clears all counters and the trip, sets the
// circumference to 190 cm and imperial units, and drops m_tvalid.
module wheel_speed_distance_calc
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] calc_enabled, [7:1] zero
    input  logic [1:0]  s_tuser,    // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [15:0] current_speed, [31:16] average_speed,
                                    // [63:32] trip_distance
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    wsdc_pkg::wsdc_cmd_t  cmd;
    wsdc_pkg::wsdc_stat_t status;
    logic [wsdc_pkg::SPEED_BITS-1:0] current_speed;
    logic [wsdc_pkg::SPEED_BITS-1:0] average_speed;
    logic [wsdc_pkg::DIST_BITS-1:0]  trip_distance;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {trip_distance, average_speed, current_speed};

    // controller
    wsdc_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .opcode       (wsdc_pkg::wsdc_op_t'(s_tuser)),
        .calc_enabled (s_tdata[0]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .status       (status),
        .cmd          (cmd)
    );

    // datapath
    wsdc_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .current_speed (current_speed),
        .average_speed (average_speed),
        .trip_distance (trip_distance)
    );

endmodule

FILE: rtl/wsdc_ctrl.sv
// wheel speed and distance calculator: controller state machine
// sequences the datapath over one calculate; depends on wsdc_pkg
`timescale 1ns / 1ps

module wsdc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  wsdc_pkg::wsdc_op_t    opcode,
    input  logic                  calc_enabled,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  wsdc_pkg::wsdc_stat_t  status,
    output wsdc_pkg::wsdc_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_LOAD,
        S_INIT,
        S_RUN,
        S_END,
        S_SPEED,
        S_DIST_WAIT,
        S_DIST_MUL,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        cmd.div_sel   = pass_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        wsdc_pkg::OP_ROT:  cmd.rot_inc  = 1'b1;
                        wsdc_pkg::OP_TICK: cmd.tick     = 1'b1;
                        wsdc_pkg::OP_TRIP: cmd.trip_clr = 1'b1;
                        wsdc_pkg::OP_CALC:
                        begin
                            if (calc_enabled)
                            begin
                                state_next = S_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul_add = 1'b1;
                pass_next   = 1'b0;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.div_load   = 1'b1;
                cmd.dist_start = !pass_reg;
                state_next     = S_INIT;
            end
            S_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_RUN;
            end
            S_RUN:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                cmd.div_end = 1'b1;
                state_next  = S_SPEED;
            end
            S_SPEED:
            begin
                cmd.speed_store = 1'b1;
                if (pass_reg)
                begin
                    state_next = S_DIST_WAIT;
                end
                else
                begin
                    pass_next  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_DIST_WAIT:
            begin
                if (!status.dist_busy)
                begin
                    state_next = S_DIST_MUL;
                end
            end
            S_DIST_MUL:
            begin
                cmd.dist_mul = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pass_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // divider iterations end in the result step
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && status.div_last) |=> state_reg == S_END)
        else $error("divider run did not end in result step");

    // the distance is ready before the result is loaded
    a_dist_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!status.dist_busy && pass_reg))
        else $error("result loaded before distance finished");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && !$past(cmd.out_load)))
        else $error("pending result overwritten");

endmodule

FILE: rtl/wsdc_dp.sv
// wheel speed and distance calculator: datapath with counters, trip sum,
// serial speed divider, divide by 100 and mile scaling; depends on wsdc_pkg
`timescale 1ns / 1ps

module wsdc_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [1:0]                         cfg_index,
    input  logic [wsdc_pkg::CIRC_BITS-1:0]     cfg_data,
    input  wsdc_pkg::wsdc_cmd_t                cmd,
    output wsdc_pkg::wsdc_stat_t               status,
    output logic [wsdc_pkg::SPEED_BITS-1:0]    current_speed,
    output logic [wsdc_pkg::SPEED_BITS-1:0]    average_speed,
    output logic [wsdc_pkg::DIST_BITS-1:0]     trip_distance
);

    localparam int D  = wsdc_pkg::DISTANCE_BITS;
    localparam int T  = wsdc_pkg::TIME_BITS;
    localparam int SW = wsdc_pkg::AW + 1;
    localparam int SPW = wsdc_pkg::QB + 15;
    localparam int DPW = wsdc_pkg::DM_W + 16;
    localparam int RW  = wsdc_pkg::DV_W + wsdc_pkg::REC_BITS;

    // configuration
    logic [wsdc_pkg::CIRC_BITS-1:0] circ_reg;
    logic                           unit_reg;

    // counters and trip state
    logic [wsdc_pkg::ROT_BITS-1:0]  rot_reg, rot_next;
    logic [D-1:0]                   total_reg, total_next;
    logic [T-1:0]                   elapsed_reg, elapsed_next;
    logic [T-1:0]                   interval_reg, interval_next;
    logic [T-1:0]                   int_snap_reg;
    logic [wsdc_pkg::ADD_BITS-1:0]  add_reg;

    // speed divider
    logic [wsdc_pkg::DVW-1:0]       n_reg;
    logic [T-1:0]                   d_reg;
    logic [T-1:0]                   rem_reg, rem_next;
    logic [wsdc_pkg::QB-1:0]        qn_reg;
    logic [wsdc_pkg::QB_CW-1:0]     div_cnt_reg;
    logic                           ovf_reg;
    logic                           zero_reg;
    logic                           sel_reg;
    logic [SPW-1:0]                 sprod_reg;
    logic [wsdc_pkg::SPEED_BITS-1:0] cur_reg, avg_reg, speed_next;

    // divide by 100
    logic [wsdc_pkg::DQ_W-1:0]      dq_reg;
    logic [wsdc_pkg::DR_W-1:0]      dr_reg, dr_next;
    logic [wsdc_pkg::DV_W-1:0]      dv_reg;
    logic [wsdc_pkg::DIG_BITS-1:0]  qd_reg;
    logic [wsdc_pkg::DQ_CW-1:0]     dcnt_reg;
    logic                           dist_busy_reg;
    logic [DPW-1:0]                 dprod_reg;

    // output register
    logic [wsdc_pkg::SPEED_BITS-1:0] out_cur_reg, out_avg_reg;
    logic [wsdc_pkg::DIST_BITS-1:0]  out_dist_reg, dist_next;

    logic [SW-1:0]                  sum_w;
    logic [wsdc_pkg::AW-1:0]        src_w;
    logic [wsdc_pkg::DVW-1:0]       sx_w, scaled_w;
    logic [T-1:0]                   divisor_w;
    logic [T:0]                     rem_ext;
    logic                           rem_ge;
    logic [wsdc_pkg::DV_W-1:0]      dv_w;
    logic [RW-1:0]                  drec_w;
    logic [63:0]                    dist_w;

    assign status.div_last  = (div_cnt_reg == wsdc_pkg::QB_CW'(wsdc_pkg::QB - 1));
    assign status.dist_busy = dist_busy_reg;
    assign current_speed    = out_cur_reg;
    assign average_speed    = out_avg_reg;
    assign trip_distance    = out_dist_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg <= wsdc_pkg::CIRC_RESET;
            unit_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == wsdc_pkg::CFG_CIRC)
            begin
                circ_reg <= cfg_data;
            end
            else if (cfg_index == wsdc_pkg::CFG_UNIT)
            begin
                unit_reg <= cfg_data[0];
            end
        end
    end

    // saturating trip sum
    assign sum_w = SW'(total_reg) + SW'(add_reg);

    // counter next values
    always_comb
    begin
        rot_next      = rot_reg;
        total_next    = total_reg;
        elapsed_next  = elapsed_reg;
        interval_next = interval_reg;
        if (cmd.trip_clr)
        begin
            rot_next      = '0;
            total_next    = '0;
            elapsed_next  = '0;
            interval_next = '0;
        end
        else if (cmd.rot_inc)
        begin
            if (rot_reg != '1)
            begin
                rot_next = rot_reg + 1'b1;
            end
        end
        else if (cmd.tick)
        begin
            if (elapsed_reg != '1)
            begin
                elapsed_next = elapsed_reg + 1'b1;
            end
            if (interval_reg != '1)
            begin
                interval_next = interval_reg + 1'b1;
            end
        end
        else if (cmd.sum)
        begin
            rot_next      = '0;
            interval_next = '0;
            total_next    = ((sum_w >> D) != '0) ? '1 : D'(sum_w);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg      <= '0;
            total_reg    <= '0;
            elapsed_reg  <= '0;
            interval_reg <= '0;
        end
        else
        begin
            rot_reg      <= rot_next;
            total_reg    <= total_next;
            elapsed_reg  <= elapsed_next;
            interval_reg <= interval_next;
        end
    end

    // interval distance and interval time snapshot
    always_ff @(posedge clk)
    begin
        if (cmd.mul_add)
        begin
            add_reg <= wsdc_pkg::ADD_BITS'(circ_reg) * wsdc_pkg::ADD_BITS'(rot_reg);
        end
        if (cmd.sum)
        begin
            int_snap_reg <= interval_reg;
        end
    end

    // numerator times 3600 as shifts and adds
    assign src_w     = cmd.div_sel ? wsdc_pkg::AW'(total_reg) : wsdc_pkg::AW'(add_reg);
    assign sx_w      = wsdc_pkg::DVW'(src_w);
    assign scaled_w  = (sx_w << 11) + (sx_w << 10) + (sx_w << 9) + (sx_w << 4);
    assign divisor_w = cmd.div_sel ? elapsed_reg : int_snap_reg;

    // one restoring step of the speed divider
    assign rem_ext  = {rem_reg, qn_reg[wsdc_pkg::QB-1]};
    assign rem_ge   = (rem_ext >= {1'b0, d_reg});
    assign rem_next = rem_ge ? T'(rem_ext - {1'b0, d_reg}) : T'(rem_ext);

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            n_reg   <= scaled_w;
            d_reg   <= divisor_w;
            sel_reg <= cmd.div_sel;
        end
        if (cmd.div_init)
        begin
            ovf_reg  <= (wsdc_pkg::CMPW'(n_reg >> wsdc_pkg::QB) >= wsdc_pkg::CMPW'(d_reg));
            zero_reg <= (d_reg == '0);
            rem_reg  <= T'(n_reg >> wsdc_pkg::QB);
            qn_reg   <= n_reg[wsdc_pkg::QB-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            qn_reg  <= {qn_reg[wsdc_pkg::QB-2:0], rem_ge};
        end
        if (cmd.div_end)
        begin
            sprod_reg <= SPW'(qn_reg[wsdc_pkg::QB-2:0]) * SPW'(wsdc_pkg::MILE_Q16);
        end
    end

    // divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // speed with zero time, saturation and unit conversion
    always_comb
    begin
        priority if (zero_reg)
        begin
            speed_next = '0;
        end
        else if (ovf_reg)
        begin
            speed_next = wsdc_pkg::SPEED_MAX;
        end
        else if (unit_reg)
        begin
            if (qn_reg[wsdc_pkg::QB-1] ||
                ((sprod_reg >> 16) > SPW'(wsdc_pkg::SPEED_MAX)))
            begin
                speed_next = wsdc_pkg::SPEED_MAX;
            end
            else
            begin
                speed_next = sprod_reg[16 +: wsdc_pkg::SPEED_BITS];
            end
        end
        else
        begin
            if (qn_reg > wsdc_pkg::QB'(wsdc_pkg::SPEED_MAX))
            begin
                speed_next = wsdc_pkg::SPEED_MAX;
            end
            else
            begin
                speed_next = qn_reg[wsdc_pkg::SPEED_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.speed_store)
        begin
            if (sel_reg)
            begin
                avg_reg <= speed_next;
            end
            else
            begin
                cur_reg <= speed_next;
            end
        end
    end

    // divide the trip centimetres by 100, one 16-bit digit at a time:
    // even step takes the quotient digit, odd step the remainder and the shift
    assign dv_w    = {dr_reg, dq_reg[wsdc_pkg::DQ_W-1 -: wsdc_pkg::DIG_BITS]};
    assign drec_w  = RW'(dv_w) * RW'(wsdc_pkg::REC_100);
    assign dr_next = wsdc_pkg::DR_W'(dv_reg - (wsdc_pkg::DV_W'(qd_reg) *
                                               wsdc_pkg::DV_W'(wsdc_pkg::CM_PER_M)));

    always_ff @(posedge clk)
    begin
        if (cmd.dist_start)
        begin
            dq_reg <= wsdc_pkg::DQ_W'(total_reg);
            dr_reg <= '0;
        end
        else if (dist_busy_reg)
        begin
            if (!dcnt_reg[0])
            begin
                dv_reg <= dv_w;
                qd_reg <= drec_w[wsdc_pkg::REC_SHIFT +: wsdc_pkg::DIG_BITS];
            end
            else
            begin
                dr_reg <= dr_next;
                dq_reg <= {dq_reg[wsdc_pkg::DQ_W-wsdc_pkg::DIG_BITS-1:0], qd_reg};
            end
        end
        if (cmd.dist_mul)
        begin
            dprod_reg <= DPW'(dq_reg[wsdc_pkg::DM_W-1:0]) * DPW'(wsdc_pkg::MILE_Q16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_busy_reg <= 1'b0;
            dcnt_reg      <= '0;
        end
        else if (cmd.dist_start)
        begin
            dist_busy_reg <= 1'b1;
            dcnt_reg      <= '0;
        end
        else if (dist_busy_reg)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
            if (dcnt_reg == wsdc_pkg::DQ_CW'(2 * wsdc_pkg::DIG_N - 1))
            begin
                dist_busy_reg <= 1'b0;
            end
        end
    end

    // distance in metres or thousandths of a mile, saturating
    assign dist_w    = unit_reg ? 64'(dprod_reg >> 16) : 64'(dq_reg);
    assign dist_next = (dist_w[63:32] != '0) ? '1 : dist_w[wsdc_pkg::DIST_BITS-1:0];

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_cur_reg  <= cur_reg;
            out_avg_reg  <= avg_reg;
            out_dist_reg <= dist_next;
        end
    end

    // trip reset clears the trip state
    a_trip_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.trip_clr |=> (total_reg == '0 && elapsed_reg == '0 && rot_reg == '0))
        else $error("trip reset left state behind");

    // partial remainder stays below the divisor during a run
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && !ovf_reg && !zero_reg) |-> (rem_reg < d_reg))
        else $error("divider remainder out of range");

    // a calculate restarts the interval
    a_interval_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum |=> (rot_reg == '0 && interval_reg == '0))
        else $error("interval not restarted");

endmodule
